// ===== hw/rtl/crop_pkg.sv =====
// Shared types, constants and helper functions for the classless route option parser.
// Used by crop_parser and classless_route_option_parser_core; depends on nothing else.
package crop_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned PREFIX_W = 6;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned OCTET_CNT_W = 3;
    localparam int unsigned OUT_DATA_W = 80;

    // Largest legal prefix length and gateway size in octets.
    localparam logic [7:0] MAX_PREFIX = 8'd32;
    localparam logic [OCTET_CNT_W-1:0] GW_OCTETS = 3'd4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

    // Configuration register indexes.
    localparam logic REG_IF_ADDRESS = 1'b0;
    localparam logic REG_IF_NETMASK = 1'b1;

    // Input beat kinds carried on tuser.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_DEST   = 2'd1,
        PH_GW     = 2'd2,
        PH_STOP   = 2'd3
    } t_phase;

    typedef struct packed {
        logic                route_valid;
        logic [ADDR_W-1:0]   dest_net;
        logic [PREFIX_W-1:0] prefix_length;
        logic [ADDR_W-1:0]   gateway_addr;
        logic                option_done;
        logic [COUNT_W-1:0]  route_count;
        logic                received;
    } t_result;

    // Network mask with the top len bits set; len runs from 0 to 32.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] len);
        prefix_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

    // Number of destination octets that follow a prefix of the given length.
    function automatic logic [OCTET_CNT_W-1:0] dest_octets(input logic [PREFIX_W-1:0] len);
        logic [PREFIX_W:0] rounded;
        rounded = {1'b0, len} + 7'd7;
        dest_octets = rounded[PREFIX_W:3] > 4'd4 ? 3'd4 : rounded[5:3];
    endfunction

    // Multicast, limited broadcast and subnet broadcast gateways are refused.
    function automatic logic gateway_rejected(input logic [ADDR_W-1:0] gw,
                                              input logic [ADDR_W-1:0] if_addr,
                                              input logic [ADDR_W-1:0] if_mask);
        logic [ADDR_W-1:0] host;
        host = ~if_mask;
        if (gw[31:28] == 4'hE) begin
            gateway_rejected = 1'b1;
        end else if (gw == {ADDR_W{1'b1}}) begin
            gateway_rejected = 1'b1;
        end else if (gw == if_addr) begin
            gateway_rejected = 1'b0;
        end else begin
            gateway_rejected = ((gw & if_mask) == (if_addr & if_mask)) &&
                               ((gw & host) == host);
        end
    endfunction

endpackage

// ===== hw/rtl/classless_route_option_parser_core.sv =====
// Top level of the classless static route option parser: stream ports, config registers,
// input and result registers. Depends on crop_pkg and crop_parser.
//
// The block takes the body of a classless static route option one byte per beat and emits
// one result beat for each byte that completes an accepted route or is the last (tlast).
// It takes one input beat per clock while the result stream is not stalled: a beat
// waits in the input register, where the parser state and gateway checks are evaluated,
// and its result is captured in the output register. Input ready drops only when the
// output register holds a beat that is not being taken. The user must write the
// interface address and netmask through the config port only while no beat is in flight;
// the block does not enforce this. They feed the subnet broadcast test on gateways.
module classless_route_option_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [crop_pkg::ADDR_W-1:0]    i_cfg_data,
    // Input stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] option_byte
    input  logic                           s_axis_tuser,   // [0] cmd
    input  logic                           s_axis_tlast,   // last_byte
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] dest_net, [37:32] prefix_length, [69:38] gateway_addr,
    // [75:70] route_count, [76] received, [79:77] zero
    output logic [crop_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tuser,   // [0] route_valid
    output logic                           m_axis_tlast    // option_done
);
    import crop_pkg::*;

    logic [ADDR_W-1:0] r_if_address;
    logic [ADDR_W-1:0] r_if_netmask;

    logic              r_in_valid;
    logic              r_in_cmd;
    logic [7:0]        r_in_byte;
    logic              r_in_last;

    logic              r_out_valid;
    t_result           r_out;

    logic              out_free;
    logic              step;
    logic              emit;
    t_result           result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_if_address <= '0;
            r_if_netmask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IF_ADDRESS: r_if_address <= i_cfg_data;
                REG_IF_NETMASK: r_if_netmask <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Handshake: the input stage moves whenever the result register can take a beat.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    crop_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_cmd        (r_in_cmd),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_if_address (r_if_address),
        .i_if_netmask (r_if_netmask),
        .o_emit       (emit),
        .o_result     (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.route_valid;
    assign m_axis_tlast  = r_out.option_done;
    assign m_axis_tdata  = {3'd0, r_out.received, r_out.route_count, r_out.gateway_addr,
                            r_out.prefix_length, r_out.dest_net};

endmodule

// ===== hw/rtl/crop_parser.sv =====
// Option body parser: entry state machine, address shift registers and route count.
// Depends on crop_pkg for the phase type, the result struct and the gateway test.
module crop_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_cmd,
    input  logic [7:0]                    i_byte,
    input  logic                          i_last,
    input  logic [crop_pkg::ADDR_W-1:0]   i_if_address,
    input  logic [crop_pkg::ADDR_W-1:0]   i_if_netmask,
    output logic                          o_emit,
    output crop_pkg::t_result             o_result
);
    import crop_pkg::*;

    t_phase                  r_phase, n_phase;
    logic [PREFIX_W-1:0]     r_prefix, n_prefix;
    logic [OCTET_CNT_W-1:0]  r_octet_cnt, n_octet_cnt;
    logic [ADDR_W-1:0]       r_dest, n_dest;
    logic [ADDR_W-1:0]       r_gw, n_gw;
    logic [COUNT_W-1:0]      r_count, n_count;
    logic                    r_received, n_received;

    logic [OCTET_CNT_W-1:0]  octet_inc;
    logic [ADDR_W-1:0]       gw_next;
    logic                    route_ok;

    assign octet_inc = r_octet_cnt + 3'd1;
    assign gw_next   = {r_gw[ADDR_W-9:0], i_byte};

    // State registers advance once per processed beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PREFIX;
            r_prefix    <= '0;
            r_octet_cnt <= '0;
            r_dest      <= '0;
            r_gw        <= '0;
            r_count     <= '0;
            r_received  <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_prefix    <= n_prefix;
            r_octet_cnt <= n_octet_cnt;
            r_dest      <= n_dest;
            r_gw        <= n_gw;
            r_count     <= n_count;
            r_received  <= n_received;
        end
    end

    // Next state and the result for the current beat.
    always_comb begin
        n_phase     = r_phase;
        n_prefix    = r_prefix;
        n_octet_cnt = r_octet_cnt;
        n_dest      = r_dest;
        n_gw        = r_gw;
        n_count     = r_count;
        n_received  = r_received;
        route_ok    = 1'b0;
        o_emit      = 1'b0;
        o_result    = '0;

        if (i_cmd == CMD_CLEAR) begin
            // Clear drops any partial entry and the sticky flag.
            n_phase     = PH_PREFIX;
            n_prefix    = '0;
            n_octet_cnt = '0;
            n_dest      = '0;
            n_gw        = '0;
            n_count     = '0;
            n_received  = 1'b0;
        end else begin
            case (r_phase)
                PH_PREFIX: begin
                    if (i_byte > MAX_PREFIX) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_prefix    = i_byte[PREFIX_W-1:0];
                        n_octet_cnt = '0;
                        n_dest      = '0;
                        n_gw        = '0;
                        n_phase     = (i_byte == 8'd0) ? PH_GW : PH_DEST;
                    end
                end
                PH_DEST: begin
                    // Destination octets fill from the most significant end.
                    case (r_octet_cnt[1:0])
                        2'd0:    n_dest = r_dest | {i_byte, 24'd0};
                        2'd1:    n_dest = r_dest | {8'd0, i_byte, 16'd0};
                        2'd2:    n_dest = r_dest | {16'd0, i_byte, 8'd0};
                        default: n_dest = r_dest | {24'd0, i_byte};
                    endcase
                    n_octet_cnt = octet_inc;
                    if (octet_inc >= dest_octets(r_prefix)) begin
                        n_octet_cnt = '0;
                        n_phase     = PH_GW;
                    end
                end
                PH_GW: begin
                    n_gw        = gw_next;
                    n_octet_cnt = octet_inc;
                    if (octet_inc >= GW_OCTETS) begin
                        n_octet_cnt = '0;
                        n_phase     = PH_PREFIX;
                        if (!gateway_rejected(gw_next, i_if_address, i_if_netmask)) begin
                            route_ok = 1'b1;
                            if (r_count != COUNT_MAX) begin
                                n_count = r_count + 6'd1;
                            end
                        end
                    end
                end
                default: begin
                    // A bad prefix length mutes the rest of the option's routes.
                end
            endcase

            if (route_ok) begin
                o_result.route_valid   = 1'b1;
                o_result.dest_net      = r_dest & prefix_mask(r_prefix);
                o_result.prefix_length = r_prefix;
                o_result.gateway_addr  = gw_next;
            end

            // The last byte reports the count and rearms the parser.
            if (i_last) begin
                o_result.option_done = 1'b1;
                o_result.route_count = n_count;
                if (n_count != '0) begin
                    n_received = 1'b1;
                end
                n_phase     = PH_PREFIX;
                n_prefix    = '0;
                n_octet_cnt = '0;
                n_dest      = '0;
                n_gw        = '0;
                n_count     = '0;
            end

            o_result.received = n_received;
            o_emit            = route_ok || i_last;
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for classless_route_option_parser_core: streams option 121 bodies in,
// predicts every route and option-end beat, and compares them with the result stream.
// Depends only on crop_pkg and the RTL of the core.
module tb_top;

    import crop_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam t_result NO_RES   = '0;

    // One row of the directed table; typed rows carry their own expectation.
    typedef struct {
        logic       cmd;
        logic [7:0] data;
        logic       last;
        bit         typed;
        bit         typed_hit;
        t_result    typed_res;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic                  i_cfg_index;
    logic [ADDR_W-1:0]     i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [7:0] option_byte
    logic                  s_axis_tuser;   // [0] cmd
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [31:0] dest_net, [37:32] prefix_length, [69:38] gateway_addr,
    // [75:70] route_count, [76] received
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;   // [0] route_valid
    logic                  m_axis_tlast;

    // Predictor state, mirrored from the parser.
    t_phase          ph;
    logic [5:0]      pfx_len;
    logic [2:0]      oct_cnt;
    logic [31:0]     dst_acc;
    logic [31:0]     gw_acc;
    logic [5:0]      route_cnt;
    logic            rcvd_flag;
    logic [31:0]     if_addr_cfg;
    logic [31:0]     if_mask_cfg;

    t_result         pending_results[$];
    t_stim_row       dir_rows[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_len       = 0;
    int stall_left     = 0;
    int cycles         = 0;
    int errors         = 0;
    int n_beats        = 0;
    int n_results      = 0;
    int n_routes       = 0;
    int n_opt_ends     = 0;

    classless_route_option_parser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: a requested hold-off first, random stalls otherwise.
    always @(posedge i_clk) begin
        if (hold_len != 0) begin
            stall_left = hold_len;
            hold_len = 0;
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    // Result monitor: every accepted beat is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.route_valid   = m_axis_tuser;
            got.dest_net      = m_axis_tdata[31:0];
            got.prefix_length = m_axis_tdata[37:32];
            got.gateway_addr  = m_axis_tdata[69:38];
            got.option_done   = m_axis_tlast;
            got.route_count   = m_axis_tdata[75:70];
            got.received      = m_axis_tdata[76];
            n_results++;
            if (got.route_valid) n_routes++;
            if (got.option_done) n_opt_ends++;
            if (pending_results.size() == 0) begin
                $error("Unexpected result beat: %h", got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("route_valid", want.route_valid, got.route_valid);
                check_field("dest_net", want.dest_net, got.dest_net);
                check_field("prefix_length", want.prefix_length, got.prefix_length);
                check_field("gateway_addr", want.gateway_addr, got.gateway_addr);
                check_field("option_done", want.option_done, got.option_done);
                check_field("route_count", want.route_count, got.route_count);
                check_field("received", want.received, got.received);
            end
        end
    end

    function automatic void restart_parse();
        ph        = PH_PREFIX;
        pfx_len   = '0;
        oct_cnt   = '0;
        dst_acc   = '0;
        gw_acc    = '0;
        route_cnt = '0;
    endfunction

    // Multicast, limited broadcast and the interface's subnet broadcast are refused;
    // the interface address itself passes unless it is multicast or all ones.
    function automatic bit gw_refused(input logic [31:0] gw);
        logic [31:0] host_bits;
        host_bits = ~if_mask_cfg;
        if (gw[31:28] == 4'hE) return 1'b1;
        if (gw == 32'hFFFF_FFFF) return 1'b1;
        if (gw == if_addr_cfg) return 1'b0;
        return ((gw & if_mask_cfg) == (if_addr_cfg & if_mask_cfg)) &&
               ((gw & host_bits) == host_bits);
    endfunction

    // Advances the parser by one accepted beat; returns 1 when a result beat follows.
    function automatic bit parse_beat(input logic cmd, input logic [7:0] data,
                                      input logic last, output t_result res);
        bit hit;
        hit = 1'b0;
        res = '0;
        if (cmd == CMD_CLEAR) begin
            rcvd_flag = 1'b0;
            restart_parse();
            return 1'b0;
        end
        case (ph)
            PH_PREFIX: begin
                if (data > MAX_PREFIX) begin
                    ph = PH_STOP;
                end else begin
                    pfx_len = data[5:0];
                    oct_cnt = '0;
                    dst_acc = '0;
                    gw_acc  = '0;
                    ph = (data == 8'd0) ? PH_GW : PH_DEST;
                end
            end
            PH_DEST: begin
                dst_acc = dst_acc | (32'(data) << (24 - 8 * oct_cnt[1:0]));
                oct_cnt = oct_cnt + 3'd1;
                if (int'(oct_cnt) >= (int'(pfx_len) + 7) / 8) begin
                    oct_cnt = '0;
                    ph = PH_GW;
                end
            end
            PH_GW: begin
                gw_acc  = {gw_acc[23:0], data};
                oct_cnt = oct_cnt + 3'd1;
                if (oct_cnt == 3'd4) begin
                    oct_cnt = '0;
                    ph = PH_PREFIX;
                    if (!gw_refused(gw_acc)) begin
                        hit = 1'b1;
                        res.route_valid   = 1'b1;
                        res.dest_net      = (pfx_len == 0) ? 32'd0 :
                                            dst_acc & (32'hFFFF_FFFF << (32 - pfx_len));
                        res.prefix_length = pfx_len;
                        res.gateway_addr  = gw_acc;
                        if (route_cnt != COUNT_MAX) route_cnt = route_cnt + 6'd1;
                    end
                end
            end
            default: ;
        endcase
        if (last) begin
            hit = 1'b1;
            res.option_done = 1'b1;
            res.route_count = route_cnt;
            if (route_cnt != 0) rcvd_flag = 1'b1;
            restart_parse();
        end
        res.received = rcvd_flag;
        return hit;
    endfunction

    // Offers one beat, with random gaps before it, and returns at its acceptance edge.
    task automatic send_beat(input logic cmd, input logic [7:0] data, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_beats++;
    endtask

    task automatic feed_beat(input logic cmd, input logic [7:0] data, input logic last);
        t_result res;
        send_beat(cmd, data, last);
        if (parse_beat(cmd, data, last, res)) pending_results.push_back(res);
    endtask

    // Sender pauses until every expected beat is back and the pipeline is empty.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] addr, input logic [31:0] mask);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_IF_ADDRESS;
        i_cfg_data  <= addr;
        @(posedge i_clk);
        i_cfg_index <= REG_IF_NETMASK;
        i_cfg_data  <= mask;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if_addr_cfg = addr;
        if_mask_cfg = mask;
    endtask

    function automatic void add_row(input logic cmd, input logic [7:0] data, input logic last,
                                    input bit typed, input bit hit, input t_result res);
        t_stim_row row;
        row.cmd       = cmd;
        row.data      = data;
        row.last      = last;
        row.typed     = typed;
        row.typed_hit = hit;
        row.typed_res = res;
        dir_rows.push_back(row);
    endfunction

    function automatic int pick_prefix();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 32;
            default: return $urandom_range(1, 31);
        endcase
    endfunction

    // Gateways aimed at each branch of the refusal test under the current settings.
    function automatic logic [31:0] pick_gateway();
        logic [31:0] rnd;
        rnd = $urandom;
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return {4'hE, rnd[27:0]};
            2:       return 32'hFFFF_FFFF;
            3:       return (if_addr_cfg & if_mask_cfg) | ~if_mask_cfg;
            4:       return if_addr_cfg;
            5:       return (if_addr_cfg & if_mask_cfg) | (rnd & ~if_mask_cfg);
            6:       return $urandom_range(1) ? 32'hDFFF_FFFF : {4'hF, rnd[27:0]};
            default: return rnd;
        endcase
    endfunction

    // One option body: mostly well-formed entries, sometimes truncated, stopped by an
    // oversized prefix, pure noise, left open, or interrupted by a clear command.
    task automatic send_option();
        logic [7:0]  body[$];
        logic [31:0] gw;
        int          roll;
        int          pfx;
        int          cut;
        int          clr_at;
        bit          keep_open;
        roll = $urandom_range(99);
        keep_open = 1'b0;
        for (int e = 0; e < $urandom_range(1, 4); e++) begin
            pfx = pick_prefix();
            body.push_back(8'(pfx));
            for (int k = 0; k < (pfx + 7) / 8; k++) body.push_back(8'($urandom));
            gw = pick_gateway();
            for (int k = 3; k >= 0; k--) body.push_back(gw[8*k +: 8]);
        end
        if (roll < 12) begin
            cut = $urandom_range(1, 6);
            if (cut >= body.size()) cut = body.size() - 1;
            repeat (cut) void'(body.pop_back());
        end else if (roll < 22) begin
            if ($urandom_range(1)) body.push_front(8'($urandom_range(33, 255)));
            else body.push_back(8'($urandom_range(33, 255)));
            repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
        end else if (roll < 27) begin
            body.delete();
            repeat ($urandom_range(1, 12)) body.push_back(8'($urandom));
        end else if (roll < 31) begin
            keep_open = 1'b1;
        end
        clr_at = ($urandom_range(99) < 5) ? $urandom_range(0, body.size() - 1) : -1;
        foreach (body[i]) begin
            if (i == clr_at) feed_beat(CMD_CLEAR, 8'($urandom), 1'($urandom));
            feed_beat(CMD_BYTE, body[i], (i == body.size() - 1) && !keep_open);
        end
    endtask

    // Main sequence: reset, directed table, then random options under several settings.
    initial begin
        t_result res;
        bit      hit;
        int      target;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_IF_ADDRESS;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_BYTE;
        s_axis_tlast  = 1'b0;
        if_addr_cfg   = '0;
        if_mask_cfg   = '0;
        rcvd_flag     = 1'b0;
        restart_parse();

        // Prefix of twelve with on-link gateway, checked by the predictor.
        add_row(CMD_BYTE, 8'd12, 1'b0, 0, 0, NO_RES);
        add_row(CMD_BYTE, 8'hAB, 1'b0, 0, 0, NO_RES);
        add_row(CMD_BYTE, 8'hCD, 1'b0, 0, 0, NO_RES);
        repeat (4) add_row(CMD_BYTE, 8'h00, 1'b0, 0, 0, NO_RES);
        // Full host route closing the option: second route, received flag set.
        add_row(CMD_BYTE, 8'd32, 1'b0, 1, 0, NO_RES);
        add_row(CMD_BYTE, 8'hC0, 1'b0, 1, 0, NO_RES);
        add_row(CMD_BYTE, 8'hA8, 1'b0, 1, 0, NO_RES);
        add_row(CMD_BYTE, 8'h01, 1'b0, 1, 0, NO_RES);
        add_row(CMD_BYTE, 8'h02, 1'b0, 1, 0, NO_RES);
        add_row(CMD_BYTE, 8'h0A, 1'b0, 1, 0, NO_RES);
        add_row(CMD_BYTE, 8'h00, 1'b0, 1, 0, NO_RES);
        add_row(CMD_BYTE, 8'h00, 1'b0, 1, 0, NO_RES);
        add_row(CMD_BYTE, 8'h01, 1'b1, 1, 1,
                '{1'b1, 32'hC0A8_0102, 6'd32, 32'h0A00_0001, 1'b1, 6'd2, 1'b1});
        // Prefix above thirty-two stops the parse; the last byte still reports.
        add_row(CMD_BYTE, 8'd33, 1'b0, 1, 0, NO_RES);
        add_row(CMD_BYTE, 8'hFF, 1'b1, 1, 1,
                '{1'b0, 32'd0, 6'd0, 32'd0, 1'b1, 6'd0, 1'b1});
        // Clear command ignores its byte and last flag and drops the received flag.
        add_row(CMD_CLEAR, 8'hFF, 1'b1, 1, 0, NO_RES);
        // Multicast gateway is refused.
        add_row(CMD_BYTE, 8'd0, 1'b0, 1, 0, NO_RES);
        add_row(CMD_BYTE, 8'hE0, 1'b0, 1, 0, NO_RES);
        add_row(CMD_BYTE, 8'h00, 1'b0, 1, 0, NO_RES);
        add_row(CMD_BYTE, 8'h00, 1'b0, 1, 0, NO_RES);
        add_row(CMD_BYTE, 8'h01, 1'b1, 1, 1,
                '{1'b0, 32'd0, 6'd0, 32'd0, 1'b1, 6'd0, 1'b0});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].last);
            hit = parse_beat(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].last, res);
            if (dir_rows[i].typed) begin
                if (dir_rows[i].typed_hit) pending_results.push_back(dir_rows[i].typed_res);
            end else if (hit) begin
                pending_results.push_back(res);
            end
        end
        drain_results();

        // Back-to-back beats on a /24, with a long receiver hold to fill the pipeline.
        set_config(32'hC0A8_010A, 32'hFFFF_FF00);
        hold_len = 70;
        target = n_beats + 150;
        while (n_beats < target) send_option();
        drain_results();

        // All-ones address and mask, sender mostly idle.
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        src_idle_pct = 79;
        target = n_beats + 150;
        while (n_beats < target) send_option();
        drain_results();

        // Random address with a random contiguous mask, receiver mostly stalled.
        set_config($urandom, 32'hFFFF_FFFF << $urandom_range(1, 31));
        src_idle_pct   = 0;
        sink_stall_pct = 79;
        target = n_beats + 150;
        while (n_beats < target) send_option();
        drain_results();

        // Zero address and mask, both sides idling; one option long enough to
        // saturate the route count.
        set_config(32'd0, 32'd0);
        src_idle_pct   = 28;
        sink_stall_pct = 28;
        for (int e = 0; e < 66; e++) begin
            repeat (4) feed_beat(CMD_BYTE, 8'h00, 1'b0);
            feed_beat(CMD_BYTE, 8'h00, e == 65);
        end
        target = n_beats + 150;
        while (n_beats < target) send_option();
        drain_results();

        // Random address, narrow mask, no idling and a second hold.
        set_config($urandom, 32'h8000_0000);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_len = 50;
        target = n_beats + 150;
        while (n_beats < target) send_option();
        drain_results();

        $display("Run covered %0d input beats and %0d result beats (%0d routes, %0d option ends)",
                 n_beats, n_results, n_routes, n_opt_ends);
        $display("across five interface settings, sender gaps, receiver stalls and long holds.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/crop_pkg.sv
hw/rtl/crop_parser.sv
hw/rtl/classless_route_option_parser_core.sv
bench/tb_top.sv
